// ===== rtl/core/lscc_pkg.sv =====
// Shared types, widths and constants of the line sensor classifier.
package lscc_pkg;

   localparam int SAMPLE_BITS  = 12;
   localparam int SENSOR_COUNT = 5;

   localparam int CFG_BITS     = 12;
   localparam int NEEDED_BITS  = 3;
   localparam int COUNT_BITS   = $clog2(SENSOR_COUNT + 1);
   localparam int QUO_BITS     = 12;
   localparam int INDEX_BITS   = 8;

   // total of up to five samples, and weights below 2**14 in sum (10000)
   localparam int TOTAL_BITS    = SAMPLE_BITS + 3;
   localparam int WEIGHTED_BITS = SAMPLE_BITS + 14;

   localparam int REQ_DATA_BITS = ((SENSOR_COUNT * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 + QUO_BITS + 7) / 8) * 8;

   localparam logic [QUO_BITS-1:0]   CENTER_POSITION     = QUO_BITS'(2000);
   localparam logic [QUO_BITS-1:0]   MAX_POSITION        = QUO_BITS'(4000);
   localparam logic [COUNT_BITS-1:0] MAX_BLACK_FOR_BROWN = COUNT_BITS'(2);

   localparam logic [QUO_BITS-1:0] WEIGHT [SENSOR_COUNT] = '{
      QUO_BITS'(0), QUO_BITS'(1000), QUO_BITS'(2000), QUO_BITS'(3000), QUO_BITS'(4000)
   };

   localparam logic [CFG_BITS-1:0]    BROWN_LOW_RESET    = '0;
   localparam logic [CFG_BITS-1:0]    BROWN_HIGH_RESET   = '0;
   localparam logic [CFG_BITS-1:0]    BLACK_LEVEL_RESET  = CFG_BITS'(4095);
   localparam logic [NEEDED_BITS-1:0] BROWN_NEEDED_RESET = NEEDED_BITS'(5);

   typedef enum logic [INDEX_BITS-1:0] {
      REG_BROWN_LOW    = INDEX_BITS'(0),
      REG_BROWN_HIGH   = INDEX_BITS'(1),
      REG_BLACK_LEVEL  = INDEX_BITS'(2),
      REG_BROWN_NEEDED = INDEX_BITS'(3)
   } reg_index_type;

   typedef logic [SAMPLE_BITS-1:0] sample_arr_type [SENSOR_COUNT];

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] brown_low;
      logic [SAMPLE_BITS-1:0] brown_high;
      logic [SAMPLE_BITS-1:0] black_level;
      logic [NEEDED_BITS-1:0] brown_needed;
   } cfg_type;

   typedef struct packed {
      logic [TOTAL_BITS-1:0] rem;
      logic [QUO_BITS-1:0]   dvd;
      logic [TOTAL_BITS-1:0] div;
      logic [QUO_BITS-1:0]   quo;
      logic                  black_seen;
      logic                  brown_crossed;
      logic                  zero_total;
   } stage_type;

endpackage

// ===== rtl/core/lscc_front.sv =====
// Front cell: classify the samples and form the weighted and plain sums.
module lscc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     valid_i,
   output logic                     ready_o,
   input  lscc_pkg::sample_arr_type samples_i,
   input  lscc_pkg::cfg_type        cfg_i,
   output logic                     valid_o,
   input  logic                     ready_i,
   output lscc_pkg::stage_type      data_o
);
   import lscc_pkg::*;

   logic                     valid_ff;
   stage_type                data_ff;
   stage_type                data_in;
   logic [TOTAL_BITS-1:0]    total;
   logic [WEIGHTED_BITS-1:0] weighted;
   logic [COUNT_BITS-1:0]    blacks;
   logic [COUNT_BITS-1:0]    browns;

   always_comb begin
      total    = '0;
      weighted = '0;
      blacks   = '0;
      browns   = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (samples_i[i] >= cfg_i.black_level) begin
            blacks   = blacks + COUNT_BITS'(1);
            total    = total + TOTAL_BITS'(samples_i[i]);
            weighted = weighted
                     + WEIGHTED_BITS'(samples_i[i]) * WEIGHTED_BITS'(WEIGHT[i]);
         end
         if (samples_i[i] >= cfg_i.brown_low && samples_i[i] <= cfg_i.brown_high) begin
            browns = browns + COUNT_BITS'(1);
         end
      end
      data_in.rem           = TOTAL_BITS'(weighted >> QUO_BITS);
      data_in.dvd           = weighted[QUO_BITS-1:0];
      data_in.div           = total;
      data_in.quo           = '0;
      data_in.black_seen    = (blacks != '0);
      data_in.brown_crossed = (blacks <= MAX_BLACK_FOR_BROWN)
                            && (browns >= COUNT_BITS'(cfg_i.brown_needed));
      data_in.zero_total    = (total == '0);
   end

   assign ready_o = !valid_ff || ready_i;
   assign valid_o = valid_ff;
   assign data_o  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_o) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_i && ready_o) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/core/lscc_div_cell.sv =====
// Divider cell: one restoring step, one quotient bit per cell.
module lscc_div_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid_i,
   output logic                ready_o,
   input  lscc_pkg::stage_type data_i,
   output logic                valid_o,
   input  logic                ready_i,
   output lscc_pkg::stage_type data_o
);
   import lscc_pkg::*;

   logic                  valid_ff;
   stage_type             data_ff;
   stage_type             data_in;
   logic [TOTAL_BITS:0]   part;
   logic [TOTAL_BITS:0]   diff;
   logic                  take;

   always_comb begin
      part    = {data_i.rem, data_i.dvd[QUO_BITS-1]};
      diff    = part - {1'b0, data_i.div};
      take    = (part >= {1'b0, data_i.div});
      data_in = data_i;
      data_in.rem = take ? diff[TOTAL_BITS-1:0] : part[TOTAL_BITS-1:0];
      data_in.dvd = {data_i.dvd[QUO_BITS-2:0], 1'b0};
      data_in.quo = {data_i.quo[QUO_BITS-2:0], take};
   end

   assign ready_o = !valid_ff || ready_i;
   assign valid_o = valid_ff;
   assign data_o  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_o) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_i && ready_o) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/core/lscc_out.sv =====
// Output register: select the centre position on a zero sum and hold the beat.
module lscc_out (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                valid_i,
   output logic                                ready_o,
   input  lscc_pkg::stage_type                 data_i,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lscc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import lscc_pkg::*;

   logic                     valid_ff;
   logic [RSP_DATA_BITS-1:0] data_ff;
   logic [RSP_DATA_BITS-1:0] data_in;
   logic [QUO_BITS-1:0]      position;

   always_comb begin
      position = data_i.zero_total ? CENTER_POSITION : data_i.quo;
      data_in  = RSP_DATA_BITS'({position, data_i.brown_crossed, data_i.black_seen});
   end

   assign ready_o    = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_o) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_i && ready_o) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/core/line_sensor_classifier_centroid.sv =====
// Top level of the line sensor classifier with weighted centroid position.
// Takes one reading of five samples per beat and returns one result beat per
// reading, in order. A new reading is taken every cycle unless the pipeline is
// full behind a stalled result port. Before its result shows on the result port,
// a reading passes the front cell, which classifies the samples and forms the
// sums and loads at the accepting edge, then twelve divider cells (one quotient
// bit per cell) and the output register. Each stage advances on its own, so a
// stalled result port only stops the input once all fourteen stages are full.
// Registers are written through the csr_ port, one write per cycle, and should
// be written while no reading is in flight; indexes beyond the register list
// are ignored.
module line_sensor_classifier_centroid (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sample_0, sample_1, sample_2, sample_3, sample_4, zero fill
   input  logic [lscc_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // black_seen, brown_crossed, line_position, zero fill
   output logic [lscc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lscc_pkg::INDEX_BITS-1:0]     csr_index,
   input  logic [lscc_pkg::CFG_BITS-1:0]       csr_data
);
   import lscc_pkg::*;

   cfg_type        cfg_ff;
   sample_arr_type samples;
   logic           valid_chain [QUO_BITS+1];
   logic           ready_chain [QUO_BITS+1];
   stage_type      data_chain  [QUO_BITS+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brown_low    <= BROWN_LOW_RESET;
         cfg_ff.brown_high   <= BROWN_HIGH_RESET;
         cfg_ff.black_level  <= BLACK_LEVEL_RESET;
         cfg_ff.brown_needed <= BROWN_NEEDED_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BROWN_LOW: begin
               cfg_ff.brown_low <= csr_data;
            end
            REG_BROWN_HIGH: begin
               cfg_ff.brown_high <= csr_data;
            end
            REG_BLACK_LEVEL: begin
               cfg_ff.black_level <= csr_data;
            end
            REG_BROWN_NEEDED: begin
               cfg_ff.brown_needed <= csr_data[NEEDED_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         samples[i] = req_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
      end
   end

   lscc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .valid_i   (req_tvalid),
      .ready_o   (req_tready),
      .samples_i (samples),
      .cfg_i     (cfg_ff),
      .valid_o   (valid_chain[0]),
      .ready_i   (ready_chain[0]),
      .data_o    (data_chain[0])
   );

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_cell
      lscc_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (valid_chain[k]),
         .ready_o (ready_chain[k]),
         .data_i  (data_chain[k]),
         .valid_o (valid_chain[k+1]),
         .ready_i (ready_chain[k+1]),
         .data_o  (data_chain[k+1])
      );
   end

   lscc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .valid_i    (valid_chain[QUO_BITS]),
      .ready_o    (ready_chain[QUO_BITS]),
      .data_i     (data_chain[QUO_BITS]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/core/lscc_checker.sv =====
// Port checker for the line sensor classifier, bound to the top level.
module lscc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [lscc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import lscc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat shown straight after reset");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[QUO_BITS+1:2] <= MAX_POSITION)
      else $error("line position beyond the rightmost sensor");

   a_no_black_centre: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[QUO_BITS+1:2] == CENTER_POSITION)
      else $error("line position off centre with no black sample");

endmodule

bind line_sensor_classifier_centroid lscc_checker u_lscc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/sv/line_reading_checker.sv =====
// Checker for the line sensor classifier: mirrors register writes, predicts and compares results.
`timescale 1ns / 100ps

module line_reading_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   // sample_0, sample_1, sample_2, sample_3, sample_4, zero fill
   input  logic [lscc_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // black_seen, brown_crossed, line_position, zero fill
   input  logic [lscc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [lscc_pkg::INDEX_BITS-1:0]    csr_index,
   input  logic [lscc_pkg::CFG_BITS-1:0]      csr_data,
   output int                                 pending_results,
   output int                                 mismatch_count
);
   import lscc_pkg::*;

   localparam int WEIGHT_STEP          = 1000;
   localparam int MAX_BLACKS_FOR_BROWN = 2;
   localparam int REPORT_LIMIT         = 10;

   typedef struct packed {
      logic                black_seen;
      logic                brown_crossed;
      logic [QUO_BITS-1:0] line_position;
   } reading_result_type;

   cfg_type            thresholds;
   reading_result_type expected_results [$];

   function automatic reading_result_type classify_reading(
      input logic [REQ_DATA_BITS-1:0] beat,
      input cfg_type                  limits
   );
      logic [SAMPLE_BITS-1:0] sample;
      int unsigned            total;
      int unsigned            weighted;
      int                     blacks;
      int                     browns;
      reading_result_type     outcome;
      total    = 0;
      weighted = 0;
      blacks   = 0;
      browns   = 0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         sample = beat[i*SAMPLE_BITS +: SAMPLE_BITS];
         if (sample >= limits.black_level) begin
            blacks++;
            total    += sample;
            weighted += sample * i * WEIGHT_STEP;
         end
         if (sample >= limits.brown_low && sample <= limits.brown_high) begin
            browns++;
         end
      end
      outcome.black_seen    = (blacks > 0);
      outcome.brown_crossed = (blacks <= MAX_BLACKS_FOR_BROWN) &&
                              (browns >= int'(limits.brown_needed));
      outcome.line_position = (total == 0) ? CENTER_POSITION : QUO_BITS'(weighted / total);
      return outcome;
   endfunction

   task automatic note_mismatch(input string detail);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $time, detail);
      end
   endtask

   always @(posedge clock) begin
      reading_result_type got;
      reading_result_type want;
      if (reset) begin
         thresholds = '{brown_low:    BROWN_LOW_RESET,
                        brown_high:   BROWN_HIGH_RESET,
                        black_level:  BLACK_LEVEL_RESET,
                        brown_needed: BROWN_NEEDED_RESET};
         expected_results.delete();
         pending_results = 0;
         mismatch_count  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.black_seen    = rsp_tdata[0];
            got.brown_crossed = rsp_tdata[1];
            got.line_position = rsp_tdata[2 +: QUO_BITS];
            if (expected_results.size() == 0) begin
               note_mismatch($sformatf("result beat with nothing expected, tdata 0x%0h",
                                       rsp_tdata));
            end else begin
               want = expected_results.pop_front();
               if (got.black_seen !== want.black_seen) begin
                  note_mismatch($sformatf("black_seen expected %0d, got %0d",
                                          want.black_seen, got.black_seen));
               end
               if (got.brown_crossed !== want.brown_crossed) begin
                  note_mismatch($sformatf("brown_crossed expected %0d, got %0d",
                                          want.brown_crossed, got.brown_crossed));
               end
               if (got.line_position !== want.line_position) begin
                  note_mismatch($sformatf("line_position expected %0d, got %0d",
                                          want.line_position, got.line_position));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(classify_reading(req_tdata, thresholds));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_BROWN_LOW:    thresholds.brown_low    = csr_data;
               REG_BROWN_HIGH:   thresholds.brown_high   = csr_data;
               REG_BLACK_LEVEL:  thresholds.black_level  = csr_data;
               REG_BROWN_NEEDED: thresholds.brown_needed = csr_data[NEEDED_BITS-1:0];
               default: ;
            endcase
         end
         pending_results = expected_results.size();
      end
   end

endmodule

// ===== tb/sv/line_sensor_classifier_centroid_tb.sv =====
// Testbench top for the line sensor classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module line_sensor_classifier_centroid_tb;
   import lscc_pkg::*;

   localparam int READINGS_PER_PHASE = 140;
   localparam int RANDOM_PHASES      = 8;
   localparam int REG_COUNT          = 4;
   localparam int PIPE_LATENCY       = 14;
   localparam int HOLD_OFF_CYCLES    = 150;
   localparam int HOLD_OFF_AFTER     = 400;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [INDEX_BITS-1:0]    csr_index;
   logic [CFG_BITS-1:0]      csr_data;

   int      pending_results;
   int      mismatch_count;
   int      accepted_readings;
   bit      req_steady;
   bit      rsp_steady;
   bit      hold_off_done;
   cfg_type settings;

   line_sensor_classifier_centroid u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   line_reading_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("line_sensor_classifier_centroid_tb: done, errors");
      $finish;
   end

   function automatic int idle_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // bias towards the thresholds now in force
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      logic [SAMPLE_BITS-1:0] near;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return SAMPLE_BITS'($urandom);
         4: near = settings.black_level;
         5: near = settings.brown_low;
         6: near = settings.brown_high;
         7: return '0;
         8: return '1;
         default: return SAMPLE_BITS'($urandom_range(settings.brown_low, settings.brown_high));
      endcase
      return near + SAMPLE_BITS'($urandom_range(0, 2)) - SAMPLE_BITS'(1);
   endfunction

   task automatic send_reading(
      input logic [SAMPLE_BITS-1:0] s0,
      input logic [SAMPLE_BITS-1:0] s1,
      input logic [SAMPLE_BITS-1:0] s2,
      input logic [SAMPLE_BITS-1:0] s3,
      input logic [SAMPLE_BITS-1:0] s4
   );
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'({s4, s3, s2, s1, s0});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accepted_readings++;
      gap = req_steady ? 0 : idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_DATA_BITS'({$urandom, $urandom});
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_register(
      input logic [INDEX_BITS-1:0] index,
      input logic [CFG_BITS-1:0]   value
   );
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // hold the input idle until every result is back and the pipe is empty
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic apply_settings(
      input logic [CFG_BITS-1:0]    low,
      input logic [CFG_BITS-1:0]    high,
      input logic [CFG_BITS-1:0]    black,
      input logic [NEEDED_BITS-1:0] needed
   );
      drain();
      write_register(REG_BROWN_LOW, low);
      write_register(REG_BROWN_HIGH, high);
      write_register(REG_BLACK_LEVEL, black);
      write_register(REG_BROWN_NEEDED, CFG_BITS'({$urandom, needed}));
      write_register(INDEX_BITS'($urandom_range(REG_COUNT, (1 << INDEX_BITS) - 1)),
                     CFG_BITS'($urandom));
      csr_valid <= 1'b0;
      settings = '{brown_low: low, brown_high: high, black_level: black,
                   brown_needed: needed};
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 149) == 0) rsp_steady = !rsp_steady;
         if (!hold_off_done && accepted_readings >= HOLD_OFF_AFTER) begin
            hold_off_done = 1'b1;
            stall_left    = HOLD_OFF_CYCLES;
         end else if (stall_left == 0 && !rsp_steady) begin
            stall_left = idle_cycles();
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      logic [SAMPLE_BITS-1:0] level;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      accepted_readings = 0;
      hold_off_done     = 1'b0;
      req_steady        = 1'b0;
      rsp_steady        = 1'b0;
      settings = '{brown_low:    BROWN_LOW_RESET,
                   brown_high:   BROWN_HIGH_RESET,
                   black_level:  BLACK_LEVEL_RESET,
                   brown_needed: BROWN_NEEDED_RESET};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one-sample window at zero, black only at full scale
      send_reading(0, 0, 0, 0, 0);
      send_reading(4095, 4095, 4095, 4095, 4095);
      send_reading(4095, 0, 0, 0, 0);
      send_reading(0, 4095, 0, 0, 0);
      send_reading(0, 0, 4095, 0, 0);
      send_reading(0, 0, 0, 4095, 0);
      send_reading(0, 0, 0, 0, 4095);
      send_reading(4095, 0, 0, 0, 4095);

      // everything black, empty brown window, no brown needed
      apply_settings(4095, 0, 0, 0);
      send_reading(0, 0, 0, 0, 0);
      send_reading(1, 0, 0, 0, 0);
      send_reading(0, 0, 0, 0, 1);
      send_reading(1, 2, 0, 0, 0);

      // full window, no brown needed: crossing hinges on the black count
      apply_settings(0, 4095, 4095, 0);
      send_reading(4095, 4095, 0, 0, 0);
      send_reading(4095, 4095, 4095, 0, 0);

      // brown counts that can never be met
      apply_settings(0, 4095, 4095, 6);
      send_reading(0, 0, 0, 0, 0);
      apply_settings(0, 4095, 4095, 7);
      send_reading(0, 0, 0, 0, 0);

      // window and black level edges
      apply_settings(100, 200, 2048, 3);
      send_reading(99, 100, 200, 201, 2047);
      send_reading(100, 150, 200, 2047, 2048);
      send_reading(2048, 2048, 4094, 150, 100);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: apply_settings(0, 4095, 4095, 5);
            1: apply_settings(1000, 3000, 2500, 2);
            2: apply_settings(3000, 1000, 0, 0);
            3: apply_settings(500, 3500, 3800, 7);
            4: apply_settings(4095, 4095, 1, 3);
            default: apply_settings(CFG_BITS'($urandom), CFG_BITS'($urandom),
                                    CFG_BITS'($urandom), NEEDED_BITS'($urandom));
         endcase
         req_steady = ($urandom_range(0, 3) == 0);
         repeat (READINGS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0) begin
               level = pick_sample();
               send_reading(level, level, level, level, level);
            end else begin
               send_reading(pick_sample(), pick_sample(), pick_sample(),
                            pick_sample(), pick_sample());
            end
         end
      end

      drain();
      if (mismatch_count == 0) begin
         $display("line_sensor_classifier_centroid_tb: done, clean");
      end else begin
         $display("line_sensor_classifier_centroid_tb: done, errors");
      end
      $finish;
   end

endmodule
